### sv/bsec_pkg.sv
// Shared types and constants for the bus string enumeration controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bsec_pkg;

  // Default string count and fixed record widths
  localparam int STRING_COUNT_DEF = 4;
  localparam int PIN_W            = 4;
  localparam int MAX_MSG          = 4;
  localparam int SLOT_W           = 2;
  localparam int CNT_W            = 3;

  // Channel widths
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Input actions
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_RESP = 2'd1;
  localparam logic [1:0] ACT_UP   = 2'd2;
  localparam logic [1:0] ACT_OFF  = 2'd3;

  // String states
  localparam logic [3:0] ST_OFF    = 4'd0;
  localparam logic [3:0] ST_UP     = 4'd1;
  localparam logic [3:0] ST_PING   = 4'd2;
  localparam logic [3:0] ST_ADDR   = 4'd3;
  localparam logic [3:0] ST_DIR    = 4'd4;
  localparam logic [3:0] ST_JUMP   = 4'd5;
  localparam logic [3:0] ST_INFO   = 4'd6;
  localparam logic [3:0] ST_ACTIVE = 4'd7;
  localparam logic [3:0] ST_REPING = 4'd8;

  // Poll kinds (two and three both mean mirror poll)
  localparam logic [1:0] PK_OFF  = 2'd0;
  localparam logic [1:0] PK_CHAN = 2'd1;
  localparam logic [1:0] PK_MIRR = 2'd2;

  // Message commands
  localparam logic [3:0] MC_NULL    = 4'd0;
  localparam logic [3:0] MC_SETADDR = 4'd1;
  localparam logic [3:0] MC_SETDIR  = 4'd2;
  localparam logic [3:0] MC_JUMP    = 4'd3;
  localparam logic [3:0] MC_SERNUM  = 4'd4;
  localparam logic [3:0] MC_VERSION = 4'd5;
  localparam logic [3:0] MC_STRING  = 4'd6;
  localparam logic [3:0] MC_GETCHAN = 4'd7;
  localparam logic [3:0] MC_GETMIRR = 4'd8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PWR_UP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PWR_ON   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INFO     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_ATT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RST_ATT  = 3'd6;

  // Commands from controller to datapath
  typedef struct packed {
    logic              accept;
    logic              exec;
    logic              load;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } bsec_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [SLOT_W-1:0] last_slot;
    logic              out_free;
  } bsec_sts_t;

endpackage

### sv/bsec_ctrl.sv
// Sequencing controller: accept, execute, then emit the result beats.
// Depends on bsec_pkg.
`timescale 1ns / 1ps

module bsec_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  bsec_pkg::bsec_sts_t sts,
  output bsec_pkg::bsec_cmd_t cmd
);
  import bsec_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Commands
  always_comb begin
    cmd.accept = (state_r == S_IDLE) && in_tvalid;
    cmd.exec   = (state_r == S_EXEC);
    cmd.load   = (state_r == S_EMIT) && sts.out_free;
    cmd.slot   = slot_r;
    cmd.last   = (slot_r == sts.last_slot);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_EMIT;
        slot_nxt  = '0;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          if (slot_r == sts.last_slot) state_nxt = S_IDLE;
          else slot_nxt = slot_r + SLOT_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
    end
  end

endmodule

### sv/bsec_dp.sv
// Datapath: configuration, per-string records, step logic, message buffer
// and output register. Depends on bsec_pkg.
`timescale 1ns / 1ps

module bsec_dp #(
  parameter int STRING_COUNT = bsec_pkg::STRING_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [bsec_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [bsec_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bsec_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [bsec_pkg::OUT_USER_W-1:0]   out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [bsec_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bsec_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  bsec_pkg::bsec_cmd_t               cmd,
  output bsec_pkg::bsec_sts_t               sts
);
  import bsec_pkg::*;

  localparam int SIDX_W = $clog2(STRING_COUNT);

  // Configuration registers
  logic [9:0] pwr_up_r, pwr_on_r, info_r;
  logic [7:0] poll_r;
  logic [3:0] retry_r, dir_att_r;
  logic [2:0] rst_att_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwr_up_r  <= 10'd500;
      pwr_on_r  <= 10'd100;
      info_r    <= 10'd100;
      poll_r    <= 8'd50;
      retry_r   <= 4'd3;
      dir_att_r <= 4'd6;
      rst_att_r <= 3'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PWR_UP:  pwr_up_r  <= cfg_wdata;
        CFG_PWR_ON:  pwr_on_r  <= cfg_wdata;
        CFG_INFO:    info_r    <= cfg_wdata;
        CFG_POLL:    poll_r    <= cfg_wdata[7:0];
        CFG_RETRY:   retry_r   <= cfg_wdata[3:0];
        CFG_DIR_ATT: dir_att_r <= cfg_wdata[3:0];
        CFG_RST_ATT: rst_att_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Latched input beat
  logic [1:0] act_in_r, tgt_r;
  logic       rv_r, qe_r, tu_r;
  logic [3:0] rt_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_in_r <= in_tuser;
      tgt_r    <= in_tdata[1:0];
      rv_r     <= in_tdata[2];
      rt_r     <= in_tdata[6:3];
      qe_r     <= in_tdata[7];
      tu_r     <= in_tdata[8];
    end
  end

  // String records and globals
  logic [3:0]        st_r [STRING_COUNT];
  logic [7:0]        ha_r [STRING_COUNT];
  logic [9:0]        dc_r [STRING_COUNT];
  logic [7:0]        pw_r [STRING_COUNT];
  logic [7:0]        pn_r [STRING_COUNT];
  logic [1:0]        pk_r [STRING_COUNT];
  logic [SIDX_W-1:0] act_r;
  logic [3:0]        dt_r;
  logic [2:0]        rc_r;
  logic              td_r;
  logic [PIN_W-1:0]  sup_r, pwr_r;

  // Step results
  logic [3:0]        st_nxt;
  logic [7:0]        ha_nxt, pw_nxt, pn_nxt;
  logic [9:0]        dc_nxt;
  logic [1:0]        pk_nxt;
  logic [SIDX_W-1:0] act_nxt;
  logic [3:0]        dt_nxt;
  logic [2:0]        rc_nxt;
  logic              td_nxt;
  logic [PIN_W-1:0]  sup_nxt, pwr_nxt;
  logic              pull_nxt;
  logic [CNT_W-1:0]  nm_nxt;
  logic              m_org [MAX_MSG];
  logic [7:0]        m_addr [MAX_MSG];
  logic [3:0]        m_cmd [MAX_MSG];
  logic [7:0]        m_data [MAX_MSG];

  logic              tgt_ok, wr_ok;
  logic [SIDX_W-1:0] sidx;

  assign tgt_ok = (int'(tgt_r) < STRING_COUNT);
  assign wr_ok  = (act_in_r == ACT_TICK) || tgt_ok;
  always_comb begin
    if (act_in_r == ACT_TICK) sidx = act_r;
    else if (tgt_ok)          sidx = tgt_r[SIDX_W-1:0];
    else                      sidx = '0;
  end

  // One step of the record logic for the selected string
  always_comb begin
    logic       go;
    logic [3:0] ns;
    logic       exh;
    logic [7:0] a;
    logic [7:0] pn_t;

    st_nxt   = st_r[sidx];
    ha_nxt   = ha_r[sidx];
    dc_nxt   = dc_r[sidx];
    pw_nxt   = pw_r[sidx];
    pn_nxt   = pn_r[sidx];
    pk_nxt   = pk_r[sidx];
    act_nxt  = act_r;
    dt_nxt   = dt_r;
    rc_nxt   = rc_r;
    td_nxt   = td_r;
    sup_nxt  = sup_r;
    pwr_nxt  = pwr_r;
    pull_nxt = 1'b0;
    nm_nxt   = '0;
    for (int i = 0; i < MAX_MSG; i++) begin
      m_org[i]  = 1'b0;
      m_addr[i] = '0;
      m_cmd[i]  = MC_NULL;
      m_data[i] = '0;
    end
    go   = 1'b0;
    ns   = ST_OFF;
    exh  = (rt_r >= retry_r);
    a    = ha_r[sidx];
    pn_t = pn_r[sidx];

    unique case (act_in_r)
      // Tick on the round-robin string
      ACT_TICK: begin
        priority case (st_r[sidx])
          ST_OFF: begin
            act_nxt = (sidx == SIDX_W'(STRING_COUNT - 1)) ? '0 : sidx + SIDX_W'(1);
          end
          ST_UP: begin
            if (dc_r[sidx] == pwr_on_r) pwr_nxt[sidx] = 1'b1;
            if (dc_r[sidx] == 10'd0) begin
              go = 1'b1;
              ns = ST_PING;
            end else begin
              dc_nxt  = dc_r[sidx] - 10'd1;
              act_nxt = (sidx == SIDX_W'(STRING_COUNT - 1)) ? '0 : sidx + SIDX_W'(1);
            end
          end
          ST_INFO: begin
            if (dc_r[sidx] != 10'd0) begin
              dc_nxt = dc_r[sidx] - 10'd1;
            end else begin
              // Four information requests in a row
              for (int i = 0; i < MAX_MSG; i++) m_addr[i] = a;
              m_cmd[0]  = MC_SERNUM;
              m_cmd[1]  = MC_VERSION;
              m_cmd[2]  = MC_STRING;
              m_cmd[3]  = MC_STRING;
              m_data[3] = 8'd1;
              nm_nxt    = CNT_W'(MAX_MSG);
              dt_nxt    = '0;
              go        = 1'b1;
              ns        = ST_ACTIVE;
            end
          end
          ST_ACTIVE: begin
            if (a == 8'd0) begin
              go = 1'b1;
              ns = ST_OFF;
            end else if (tu_r) begin
              // polling held off
            end else if (pw_r[sidx] != 8'd0 && !qe_r) begin
              pw_nxt = pw_r[sidx] - 8'd1;
            end else begin
              pw_nxt = poll_r;
              if (pn_t == 8'd0 || pn_t > a) pn_t = 8'd1;
              pn_nxt = pn_t;
              if (pk_r[sidx] == PK_OFF) begin
                // no poll
              end else if (pk_r[sidx] == PK_CHAN) begin
                m_addr[0] = pn_t;
                m_cmd[0]  = MC_GETCHAN;
                nm_nxt    = CNT_W'(1);
                pk_nxt    = PK_MIRR;
              end else begin
                m_addr[0] = pn_t;
                m_cmd[0]  = MC_GETMIRR;
                nm_nxt    = CNT_W'(1);
                pk_nxt    = PK_CHAN;
                pn_nxt    = pn_t + 8'd1;
              end
            end
            act_nxt = (sidx == SIDX_W'(STRING_COUNT - 1)) ? '0 : sidx + SIDX_W'(1);
          end
          default: ;
        endcase
      end
      // Response to the head message
      ACT_RESP: begin
        pull_nxt = 1'b1;
        if (tgt_ok) begin
          priority case (st_r[sidx])
            ST_PING: begin
              if (rv_r) begin
                dt_nxt = '0;
                go     = 1'b1;
                ns     = ST_ADDR;
              end else begin
                pull_nxt = 1'b0;
                if (exh) begin
                  go = 1'b1;
                  ns = ST_INFO;
                end
              end
            end
            ST_ADDR: begin
              if (!rv_r && !exh) begin
                pull_nxt = 1'b0;
              end else begin
                td_nxt = 1'b0;
                dt_nxt = '0;
                go     = 1'b1;
                ns     = ST_DIR;
              end
            end
            ST_DIR: begin
              if (rv_r) begin
                dt_nxt = '0;
                go     = 1'b1;
                ns     = ST_JUMP;
              end else begin
                dt_nxt = (dt_r != 4'd15) ? dt_r + 4'd1 : dt_r;
                if (dt_nxt < dir_att_r) begin
                  td_nxt = ~td_r;
                  go     = 1'b1;
                  ns     = ST_DIR;
                end else begin
                  pull_nxt = 1'b0;
                  if (a != 8'd0) ha_nxt = a - 8'd1;
                  rc_nxt = (rc_r != 3'd7) ? rc_r + 3'd1 : rc_r;
                  go     = 1'b1;
                  if (rc_nxt < rst_att_r) begin
                    dt_nxt = '0;
                    ns     = ST_PING;
                  end else begin
                    ns = ST_INFO;
                  end
                end
              end
            end
            ST_JUMP: begin
              if (rv_r) begin
                go = 1'b1;
                ns = ST_PING;
              end else if (!exh) begin
                pull_nxt = 1'b0;
              end else begin
                go = 1'b1;
                ns = ST_REPING;
              end
            end
            ST_REPING: begin
              if (rv_r) begin
                go = 1'b1;
                ns = ST_PING;
              end else if (!exh) begin
                pull_nxt = 1'b0;
              end else begin
                if (a != 8'd0) ha_nxt = a - 8'd1;
                go = 1'b1;
                ns = ST_INFO;
              end
            end
            default: ;
          endcase
        end
      end
      // Power up or power off a string
      default: begin
        if (tgt_ok) begin
          go = 1'b1;
          ns = (act_in_r == ACT_UP) ? ST_UP : ST_OFF;
        end
      end
    endcase

    // State entry actions
    if (go) begin
      unique case (ns)
        ST_OFF: begin
          sup_nxt[sidx] = 1'b1;
          pwr_nxt[sidx] = 1'b0;
          ha_nxt        = '0;
          rc_nxt        = '0;
        end
        ST_UP: begin
          sup_nxt[sidx] = 1'b0;
          pwr_nxt[sidx] = 1'b0;
          ha_nxt        = '0;
          dc_nxt        = pwr_up_r;
        end
        ST_PING: begin
          m_org[0] = 1'b1;
          nm_nxt   = CNT_W'(1);
        end
        ST_ADDR: begin
          if (ha_nxt != 8'hFF) ha_nxt = ha_nxt + 8'd1;
          m_org[0]  = 1'b1;
          m_cmd[0]  = MC_SETADDR;
          m_data[0] = ha_nxt;
          nm_nxt    = CNT_W'(1);
        end
        ST_DIR: begin
          m_org[0]  = 1'b1;
          m_addr[0] = ha_nxt;
          m_cmd[0]  = MC_SETDIR;
          m_data[0] = {7'd0, td_nxt};
          nm_nxt    = CNT_W'(1);
        end
        ST_JUMP: begin
          m_org[0]  = 1'b1;
          m_addr[0] = ha_nxt;
          m_cmd[0]  = MC_JUMP;
          nm_nxt    = CNT_W'(1);
        end
        ST_INFO: begin
          dc_nxt = info_r;
        end
        ST_ACTIVE: begin
          pk_nxt = PK_CHAN;
          pn_nxt = 8'd1;
        end
        ST_REPING: begin
          m_org[0]  = 1'b1;
          m_addr[0] = ha_nxt;
          nm_nxt    = CNT_W'(1);
        end
        default: ;
      endcase
      st_nxt = ns;
    end
  end

  // Record write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STRING_COUNT; i++) begin
        st_r[i] <= ST_OFF;
        ha_r[i] <= '0;
        dc_r[i] <= '0;
        pw_r[i] <= '0;
        pn_r[i] <= 8'd1;
        pk_r[i] <= PK_CHAN;
      end
      act_r <= '0;
      dt_r  <= '0;
      rc_r  <= '0;
      td_r  <= 1'b0;
      sup_r <= '1;
      pwr_r <= '0;
    end else if (cmd.exec) begin
      if (wr_ok) begin
        st_r[sidx] <= st_nxt;
        ha_r[sidx] <= ha_nxt;
        dc_r[sidx] <= dc_nxt;
        pw_r[sidx] <= pw_nxt;
        pn_r[sidx] <= pn_nxt;
        pk_r[sidx] <= pk_nxt;
      end
      act_r <= act_nxt;
      dt_r  <= dt_nxt;
      rc_r  <= rc_nxt;
      td_r  <= td_nxt;
      sup_r <= sup_nxt;
      pwr_r <= pwr_nxt;
    end
  end

  // Message buffer for the current item
  logic              b_org_r [MAX_MSG];
  logic [7:0]        b_addr_r [MAX_MSG];
  logic [3:0]        b_cmd_r [MAX_MSG];
  logic [7:0]        b_data_r [MAX_MSG];
  logic [CNT_W-1:0]  b_cnt_r;
  logic [1:0]        b_str_r;
  logic              b_pull_r;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < MAX_MSG; i++) begin
        b_org_r[i]  <= m_org[i];
        b_addr_r[i] <= m_addr[i];
        b_cmd_r[i]  <= m_cmd[i];
        b_data_r[i] <= m_data[i];
      end
      b_cnt_r  <= nm_nxt;
      b_str_r  <= (act_in_r == ACT_TICK) ? 2'(act_r) : tgt_r;
      b_pull_r <= pull_nxt;
    end
  end

  assign sts.last_slot = (b_cnt_r == '0) ? '0 : SLOT_W'(b_cnt_r - CNT_W'(1));

  // Output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_msg_r;
  logic                  out_last_r;
  logic                  slot_msg;

  assign sts.out_free = !out_valid_r || out_tready;
  assign slot_msg     = (CNT_W'(cmd.slot) < b_cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_msg_r  <= slot_msg;
      out_last_r <= cmd.last;
      out_data_r <= {pwr_r, sup_r, b_pull_r, b_data_r[cmd.slot], b_cmd_r[cmd.slot],
                     b_addr_r[cmd.slot], (slot_msg ? b_str_r : 2'd0), b_org_r[cmd.slot]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_msg_r;
  assign out_tlast  = out_last_r;

endmodule

### sv/bus_string_enumeration_controller.sv
// Flow: an accepted beat is worked in the execute state, then its result beats are loaded
// into the output register one per cycle while the sink is ready (one to four per item).
// A new item is taken only after the last result beat of the current one has been loaded
// into the one-beat output register.
// Reset: rst_n synchronous, active low; restores all string records and the register
// defaults, sets every supply enable bit and clears every node power enable bit.
`timescale 1ns / 1ps

module bus_string_enumeration_controller #(
  parameter int STRING_COUNT = bsec_pkg::STRING_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // tdata: target_string[1:0], resp_valid[2], tx_retries[6:3], queue_empty[7],
  //        test_update[8], zero [15:9]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bsec_pkg::IN_DATA_W-1:0]  in_tdata,
  // tuser: action[1:0]
  input  logic [bsec_pkg::IN_USER_W-1:0]  in_tuser,
  // tdata: msg_origin[0], msg_string[2:1], msg_addr[10:3], msg_cmd[14:11],
  //        msg_data[22:15], pull_message[23], supply_enables[27:24], power_enables[31:28]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bsec_pkg::OUT_DATA_W-1:0] out_tdata,
  // tuser: msg_valid[0]
  output logic [bsec_pkg::OUT_USER_W-1:0] out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [bsec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsec_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bsec_pkg::*;

  bsec_cmd_t cmd;
  bsec_sts_t sts;

  bsec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bsec_dp #(
    .STRING_COUNT (STRING_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

### sv/bsec_chk.sv
// Port-level checks for the bus string enumeration controller, bound to the top level.
// Depends on bsec_pkg and bus_string_enumeration_controller.
`timescale 1ns / 1ps

module bsec_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bsec_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [bsec_pkg::OUT_USER_W-1:0] out_tuser,
  input logic                            out_tlast
);
  import bsec_pkg::*;

  // Result beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat dropped or changed under stall");

  // Accepted item is worked before another is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted during execution");

  // No new item while results of the current one remain
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("item accepted before all results were staged");

  // A beat without a message is the only beat of its item
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast)
    else $error("message-less beat is not the last beat");

endmodule

bind bus_string_enumeration_controller bsec_chk u_bsec_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
